@@ design/ktp_pkg.sv @@
// ----------------------------------------------------------------------------
// ktp_pkg
// Shared types and constants of the keyed timer pool: command codes,
// classified operations, queue item layout and sizes.
// ----------------------------------------------------------------------------
package ktp_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TICK_W     = 16;
   localparam int KEY_W      = 8;
   localparam int SECS_W     = 8;
   localparam int TPS_W      = 6;
   localparam int REQ_W      = SECS_W + TPS_W;
   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W     = $clog2(QDEPTH + 1);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TPS_W-1:0] TPS_60 = TPS_W'(60);
   localparam logic [TPS_W-1:0] TPS_50 = TPS_W'(50);

   // ceil(2^RECIP_SHIFT / rate): exact floor division of any REQ_W-bit count
   localparam int RECIP_W     = 15;
   localparam int RECIP_SHIFT = 20;
   localparam int QUOT_W      = SECS_W + 1;
   localparam int PROD_W      = REQ_W + RECIP_W;

   localparam logic [RECIP_W-1:0] RECIP_60 = RECIP_W'(17477);
   localparam logic [RECIP_W-1:0] RECIP_50 = RECIP_W'(20972);

   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_CREATE = 3'd1;
   localparam logic [2:0] CMD_REMOVE = 3'd2;
   localparam logic [2:0] CMD_COUNT  = 3'd3;
   localparam logic [2:0] CMD_REMAIN = 3'd4;

   localparam logic REG_RATE = 1'b0;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_CREATE,
      OP_REMOVE,
      OP_COUNT,
      OP_REMAIN,
      OP_DONE_NOW,
      OP_NONE
   } ktp_op_type;

   typedef struct packed {
      ktp_op_type        op;
      logic [KEY_W-1:0]  key;
      logic [SECS_W-1:0] secs;
      logic [REQ_W-1:0]  req;
   } ktp_item_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_FIND,
      B_UPDATE,
      B_DIV,
      B_LEFT,
      B_OUT
   } ktp_state_type;

endpackage

@@ design/ktp_front.sv @@
// ----------------------------------------------------------------------------
// ktp_front
// Command front end: accepts commands, classifies them and computes the
// target tick count before handing them to the command queue.
// ----------------------------------------------------------------------------
module ktp_front
   import ktp_pkg::*;
(
   input  logic              push,
   output logic              full,
   input  logic [2:0]        req_cmd,
   input  logic [KEY_W-1:0]  req_timer_id,
   input  logic [SECS_W-1:0] req_seconds,
   input  logic              rate_60,
   input  logic              q_full,
   output logic              q_push,
   output ktp_item_type      q_item
);

   logic [REQ_W-1:0] secs_ext;
   logic [REQ_W-1:0] tps_ext;
   logic             secs_zero;

   assign full      = q_full;
   assign q_push    = push && !q_full;
   assign secs_ext  = REQ_W'(req_seconds);
   assign tps_ext   = REQ_W'(rate_60 ? TPS_60 : TPS_50);
   assign secs_zero = (req_seconds == '0);

   always_comb begin
      q_item.key  = req_timer_id;
      q_item.secs = req_seconds;
      q_item.req  = secs_ext * tps_ext;
      case (req_cmd)
         CMD_TICK:   q_item.op = OP_TICK;
         CMD_CREATE: q_item.op = OP_CREATE;
         CMD_REMOVE: q_item.op = OP_REMOVE;
         CMD_COUNT:  q_item.op = secs_zero ? OP_DONE_NOW : OP_COUNT;
         CMD_REMAIN: q_item.op = secs_zero ? OP_NONE : OP_REMAIN;
         default:    q_item.op = OP_NONE;
      endcase
   end

endmodule

@@ design/ktp_queue.sv @@
// ----------------------------------------------------------------------------
// ktp_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ktp_queue
   import ktp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_push,
   input  ktp_item_type q_item,
   output logic         q_full,
   input  logic         q_pop,
   output logic         q_empty,
   output ktp_item_type q_head
);

   ktp_item_type      mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign q_full  = (count_ff == QCNT_W'(QDEPTH));
   assign q_empty = (count_ff == '0);
   assign q_head  = mem_ff[rd_ptr_ff];
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_item;
      end
   end

endmodule

@@ design/ktp_back.sv @@
// ----------------------------------------------------------------------------
// ktp_back
// Command back end: slot pool, tick counter, key search, timer update,
// reciprocal division into seconds and the result register.
// ----------------------------------------------------------------------------
module ktp_back
   import ktp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rate_60,
   input  logic              q_empty,
   input  ktp_item_type      q_head,
   output logic              q_pop,
   output logic              empty,
   input  logic              pop,
   output logic              rsp_done_res,
   output logic [SECS_W-1:0] rsp_seconds_left,
   output logic              rsp_pool_full
);

   ktp_state_type     state_ff, state_in;
   ktp_item_type      cur_ff, cur_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [REQ_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic              res_done_ff, res_done_in;
   logic              res_full_ff, res_full_in;
   logic [SECS_W-1:0] res_left_ff, res_left_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_done_ff, rsp_done_in;
   logic              rsp_full_ff, rsp_full_in;
   logic [SECS_W-1:0] rsp_left_ff, rsp_left_in;

   logic [SLOTS-1:0]  used_ff, used_in;
   logic [SLOTS-1:0]  running_ff, running_in;
   logic [SLOTS-1:0]  finished_ff, finished_in;
   logic [KEY_W-1:0]  key_ff [SLOTS];
   logic [KEY_W-1:0]  key_in [SLOTS];
   logic [TICK_W-1:0] start_ff [SLOTS];
   logic [TICK_W-1:0] start_in [SLOTS];
   logic [REQ_W-1:0]  target_ff [SLOTS];
   logic [REQ_W-1:0]  target_in [SLOTS];
   logic [TICK_W-1:0] tick_ff, tick_in;

   logic [SLOTS-1:0]  hit_vec;
   logic              hit_any;
   logic [SLOT_W-1:0] hit_idx;
   logic              free_any;
   logic [SLOT_W-1:0] free_idx;
   logic [SLOT_W-1:0] claim_idx;

   logic              same_tgt;
   logic              fin_ret;
   logic              keep;
   logic [TICK_W-1:0] eff_start;
   logic [REQ_W-1:0]  eff_tgt;
   logic [TICK_W-1:0] elapsed;
   logic              reached;
   logic [RECIP_W-1:0] recip;
   logic [PROD_W-1:0] prod;

   assign empty            = !rsp_valid_ff;
   assign rsp_done_res     = rsp_done_ff;
   assign rsp_seconds_left = rsp_left_ff;
   assign rsp_pool_full    = rsp_full_ff;
   assign q_pop            = (state_ff == B_IDLE) && !q_empty;
   assign recip            = rate_60 ? RECIP_60 : RECIP_50;

   always_comb begin
      hit_any  = 1'b0;
      hit_idx  = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         hit_vec[i] = used_ff[i] && (key_ff[i] == cur_ff.key);
         if (hit_vec[i]) begin
            hit_any = 1'b1;
            hit_idx = SLOT_W'(i);
         end
         if (!used_ff[i]) begin
            free_any = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
      claim_idx = hit_any ? hit_idx : free_idx;
   end

   always_comb begin
      same_tgt  = (target_ff[idx_ff] == cur_ff.req);
      fin_ret   = finished_ff[idx_ff] && same_tgt;
      keep      = running_ff[idx_ff] && same_tgt;
      eff_start = (fin_ret || keep) ? start_ff[idx_ff] : tick_ff;
      eff_tgt   = (fin_ret || keep) ? target_ff[idx_ff] : cur_ff.req;
      elapsed   = tick_ff - eff_start;
      reached   = (elapsed >= TICK_W'(eff_tgt));
      prod      = PROD_W'(rem_ff) * PROD_W'(recip);
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      res_done_in  = res_done_ff;
      res_full_in  = res_full_ff;
      res_left_in  = res_left_ff;
      used_in      = used_ff;
      running_in   = running_ff;
      finished_in  = finished_ff;
      key_in       = key_ff;
      start_in     = start_ff;
      target_in    = target_ff;
      tick_in      = tick_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      rsp_done_in  = rsp_done_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_left_in  = rsp_left_ff;

      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               cur_in      = q_head;
               res_done_in = 1'b0;
               res_full_in = 1'b0;
               res_left_in = '0;
               state_in    = B_FIND;
            end
         end
         B_FIND: begin
            state_in = B_OUT;
            case (cur_ff.op)
               OP_TICK: begin
                  tick_in = tick_ff + 1'b1;
               end
               OP_DONE_NOW: begin
                  res_done_in = 1'b1;
               end
               OP_REMOVE: begin
                  if (hit_any) begin
                     used_in[hit_idx]     = 1'b0;
                     running_in[hit_idx]  = 1'b0;
                     finished_in[hit_idx] = 1'b0;
                  end
               end
               OP_CREATE, OP_COUNT, OP_REMAIN: begin
                  if (hit_any || free_any) begin
                     if (cur_ff.op == OP_CREATE || !hit_any) begin
                        used_in[claim_idx]     = 1'b1;
                        key_in[claim_idx]      = cur_ff.key;
                        running_in[claim_idx]  = 1'b0;
                        finished_in[claim_idx] = 1'b0;
                        start_in[claim_idx]    = '0;
                        target_in[claim_idx]   = '0;
                     end
                     if (cur_ff.op != OP_CREATE) begin
                        idx_in   = claim_idx;
                        state_in = B_UPDATE;
                     end
                  end else begin
                     res_full_in = 1'b1;
                     if (cur_ff.op == OP_REMAIN) begin
                        res_left_in = cur_ff.secs;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         B_UPDATE: begin
            if (!fin_ret && !keep) begin
               running_in[idx_ff]  = 1'b1;
               finished_in[idx_ff] = 1'b0;
               start_in[idx_ff]    = tick_ff;
               target_in[idx_ff]   = cur_ff.req;
            end
            if (cur_ff.op == OP_REMAIN) begin
               rem_in   = reached ? eff_tgt : elapsed[REQ_W-1:0];
               state_in = B_DIV;
            end else begin
               if (fin_ret) begin
                  res_done_in = 1'b1;
               end else if (reached) begin
                  finished_in[idx_ff] = 1'b1;
                  running_in[idx_ff]  = 1'b0;
                  res_done_in         = 1'b1;
               end
               state_in = B_OUT;
            end
         end
         B_DIV: begin
            quot_in  = prod[RECIP_SHIFT +: QUOT_W];
            state_in = B_LEFT;
         end
         B_LEFT: begin
            res_left_in = (quot_ff >= QUOT_W'(cur_ff.secs)) ? '0
                          : cur_ff.secs - quot_ff[SECS_W-1:0];
            state_in    = B_OUT;
         end
         B_OUT: begin
            if (!rsp_valid_ff || pop) begin
               rsp_valid_in = 1'b1;
               rsp_done_in  = res_done_ff;
               rsp_full_in  = res_full_ff;
               rsp_left_in  = res_left_ff;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         used_ff      <= '0;
         running_ff   <= '0;
         finished_ff  <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         running_ff   <= running_in;
         finished_ff  <= finished_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      res_done_ff <= res_done_in;
      res_full_ff <= res_full_in;
      res_left_ff <= res_left_in;
      rsp_done_ff <= rsp_done_in;
      rsp_full_ff <= rsp_full_in;
      rsp_left_ff <= rsp_left_in;
      key_ff      <= key_in;
      start_ff    <= start_in;
      target_ff   <= target_in;
   end

`ifndef SYNTHESIS
   a_unique_key: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("two used slots hold the same key");

   a_run_xor_fin: assert property (@(posedge clock) disable iff (reset)
      (running_ff & finished_ff) == '0)
      else $error("slot both running and finished");

   a_run_used: assert property (@(posedge clock) disable iff (reset)
      ((running_ff | finished_ff) & ~used_ff) == '0)
      else $error("timer active in a free slot");

   a_left_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_OUT && res_left_ff != '0) |-> (cur_ff.op == OP_REMAIN))
      else $error("seconds left on a command other than remaining seconds");
`endif

endmodule

@@ design/keyed_timer_pool_seconds.sv @@
// ----------------------------------------------------------------------------
// keyed_timer_pool_seconds
// Pool of keyed second timers on a wrapping tick counter, with command
// queue front end, sequenced back end and an APB-style rate register.
//
//   Channel   Handshake        Payload
//   command   push / full      req_cmd, req_timer_id, req_seconds
//   result    pop / empty      rsp_done_res, rsp_seconds_left, rsp_pool_full
//   register  psel / penable   paddr, pwdata, prdata (rate_is_60hz at 0x0)
//
// A command passes the back-end sequencer states idle, find and output (tick, create,
// remove, unused codes, zero durations, full pool), adds update (count seconds) or adds
// update, divide and subtract (remaining seconds); the reciprocal multiply and the
// subtraction from the requested seconds make the longest path.
// Two commands queue ahead of the back end; full rises only when both wait.
// A result waiting in the output register stalls the back end, not the queue.
// Reset empties the pool, clears the tick counter and selects 60 ticks/s.
// ----------------------------------------------------------------------------
module keyed_timer_pool_seconds
   import ktp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [2:0]            req_cmd,
   input  logic [KEY_W-1:0]      req_timer_id,
   input  logic [SECS_W-1:0]     req_seconds,
   output logic                  empty,
   input  logic                  pop,
   output logic                  rsp_done_res,
   output logic [SECS_W-1:0]     rsp_seconds_left,
   output logic                  rsp_pool_full,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic         rate_ff, rate_in;
   logic         q_push;
   logic         q_full;
   logic         q_pop;
   logic         q_empty;
   ktp_item_type q_item;
   ktp_item_type q_head;
   logic         reg_hit;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[CSR_ADDR_W-1:2] == REG_RATE);
   assign prdata  = reg_hit ? CSR_DATA_W'(rate_ff) : '0;
   assign rate_in = (psel && penable && pwrite && reg_hit) ? pwdata[0] : rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= 1'b1;
      end else begin
         rate_ff <= rate_in;
      end
   end

   ktp_front u_front (
      .push         (push),
      .full         (full),
      .req_cmd      (req_cmd),
      .req_timer_id (req_timer_id),
      .req_seconds  (req_seconds),
      .rate_60      (rate_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_item       (q_item)
   );

   ktp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_item  (q_item),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_head  (q_head)
   );

   ktp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .rate_60          (rate_ff),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .empty            (empty),
      .pop              (pop),
      .rsp_done_res     (rsp_done_res),
      .rsp_seconds_left (rsp_seconds_left),
      .rsp_pool_full    (rsp_pool_full)
   );

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed timer pool. A built-in predictor tracks
// slots, tick counter and rate, and each result transfer is compared with
// the oldest expected reply. Tests cover zero durations, spare command codes,
// pool overflow, expiry at both rates, random traffic with stalls on both
// sides, a long result hold-off and a back-to-back run at 60 ticks/s.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ktp_pkg::*;

   localparam logic [2:0]            CMD_LAST    = '1;
   localparam logic [CSR_ADDR_W-1:0] RATE_ADDR   = CSR_ADDR_W'(4 * REG_RATE);
   localparam int                    NO_SLOT     = -1;
   localparam int                    HOLD_CYCLES = 200;
   localparam int                    DRAIN_CYCLES = 16;
   localparam int                    MAX_REPORTS = 20;
   localparam int                    PHASES      = 5;
   localparam int                    PHASE_ITEMS = 260;
   localparam int                    KEY_BASE    = 8'h40;
   localparam int                    KEY_SPAN    = 20;
   localparam logic [KEY_W-1:0]      KEY_A       = 8'hA1;
   localparam logic [KEY_W-1:0]      KEY_B       = 8'hB2;
   localparam logic [KEY_W-1:0]      KEY_C       = 8'hC3;
   localparam int                    SETTLE_TICKS = 70;

   typedef struct packed {
      logic              done_res;
      logic [SECS_W-1:0] seconds_left;
      logic              pool_full;
   } reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [2:0]            req_cmd = CMD_TICK;
   logic [KEY_W-1:0]      req_timer_id = '0;
   logic [SECS_W-1:0]     req_seconds = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic                  rsp_done_res;
   logic [SECS_W-1:0]     rsp_seconds_left;
   logic                  rsp_pool_full;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bit        idling = 1'b1;
   int        pop_hold_request = 0;
   int        error_count = 0;
   reply_type pending_replies[$];

   logic              rate_60;
   logic              pool_used[SLOTS];
   logic [KEY_W-1:0]  pool_key[SLOTS];
   logic              pool_running[SLOTS];
   logic              pool_finished[SLOTS];
   logic [TICK_W-1:0] pool_start[SLOTS];
   logic [TICK_W-1:0] pool_target[SLOTS];
   logic [TICK_W-1:0] tick_now;

   keyed_timer_pool_seconds DUT (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_cmd          (req_cmd),
      .req_timer_id     (req_timer_id),
      .req_seconds      (req_seconds),
      .empty            (empty),
      .pop              (pop),
      .rsp_done_res     (rsp_done_res),
      .rsp_seconds_left (rsp_seconds_left),
      .rsp_pool_full    (rsp_pool_full),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #5 clock = ~clock;

   function automatic logic [TICK_W-1:0] ticks_per_second();
      return rate_60 ? TICK_W'(TPS_60) : TICK_W'(TPS_50);
   endfunction

   function automatic void clear_slot(int s, logic used, logic [KEY_W-1:0] key);
      pool_used[s]     = used;
      pool_key[s]      = key;
      pool_running[s]  = 1'b0;
      pool_finished[s] = 1'b0;
      pool_start[s]    = '0;
      pool_target[s]   = '0;
   endfunction

   function automatic int lookup_key(logic [KEY_W-1:0] key);
      for (int s = 0; s < SLOTS; s++)
         if (pool_used[s] && pool_key[s] == key)
            return s;
      return NO_SLOT;
   endfunction

   function automatic int lookup_or_take(logic [KEY_W-1:0] key);
      int s;
      s = lookup_key(key);
      if (s != NO_SLOT)
         return s;
      for (int i = 0; i < SLOTS; i++) begin
         if (!pool_used[i]) begin
            clear_slot(i, 1'b1, key);
            return i;
         end
      end
      return NO_SLOT;
   endfunction

   // restart unless the same target is already running or finished
   function automatic logic arm_timer(int s, logic [SECS_W-1:0] secs);
      logic [TICK_W-1:0] goal;
      goal = TICK_W'(secs) * ticks_per_second();
      if (pool_finished[s] && pool_target[s] == goal)
         return 1'b1;
      if (pool_running[s] && pool_target[s] == goal)
         return 1'b0;
      pool_running[s]  = 1'b1;
      pool_finished[s] = 1'b0;
      pool_start[s]    = tick_now;
      pool_target[s]   = goal;
      return 1'b0;
   endfunction

   function automatic reply_type predict_reply(logic [2:0] cmd, logic [KEY_W-1:0] key,
                                               logic [SECS_W-1:0] secs);
      reply_type         r;
      int                s;
      logic [TICK_W-1:0] spent;
      logic [TICK_W-1:0] whole;
      r = '0;
      case (cmd)
         CMD_TICK: begin
            tick_now = tick_now + 1'b1;
         end
         CMD_CREATE: begin
            s = lookup_or_take(key);
            if (s == NO_SLOT)
               r.pool_full = 1'b1;
            else
               clear_slot(s, 1'b1, key);
         end
         CMD_REMOVE: begin
            s = lookup_key(key);
            if (s != NO_SLOT)
               clear_slot(s, 1'b0, '0);
         end
         CMD_COUNT: begin
            if (secs == '0) begin
               r.done_res = 1'b1;
            end else begin
               s = lookup_or_take(key);
               if (s == NO_SLOT) begin
                  r.pool_full = 1'b1;
               end else if (arm_timer(s, secs) || pool_finished[s]) begin
                  r.done_res = 1'b1;
               end else begin
                  spent = tick_now - pool_start[s];
                  if (spent >= pool_target[s]) begin
                     pool_finished[s] = 1'b1;
                     pool_running[s]  = 1'b0;
                     r.done_res       = 1'b1;
                  end
               end
            end
         end
         CMD_REMAIN: begin
            if (secs != '0) begin
               s = lookup_or_take(key);
               if (s == NO_SLOT) begin
                  r.pool_full    = 1'b1;
                  r.seconds_left = secs;
               end else begin
                  void'(arm_timer(s, secs));
                  spent = tick_now - pool_start[s];
                  if (spent > pool_target[s])
                     spent = pool_target[s];
                  whole = spent / ticks_per_second();
                  r.seconds_left = (whole >= TICK_W'(secs)) ? '0
                                   : SECS_W'(TICK_W'(secs) - whole);
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_command(input logic [2:0] cmd, input logic [KEY_W-1:0] key,
                               input logic [SECS_W-1:0] secs);
      req_cmd      <= cmd;
      req_timer_id <= key;
      req_seconds  <= secs;
      push         <= 1'b1;
      do @(posedge clock); while (full);
      pending_replies.push_back(predict_reply(cmd, key, secs));
   endtask

   task automatic hold_input(int cycles);
      push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic pace_input();
      if (idling && $urandom_range(0, 5) == 0)
         hold_input($urandom_range(1, 9));
   endtask

   task automatic wait_for_replies();
      push <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   task automatic check_rate();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= RATE_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_W'(rate_60)) begin
         if (error_count < MAX_REPORTS)
            $display("%0t: rate readback mismatch: expected %0h, actual %0h",
                     $time, CSR_DATA_W'(rate_60), prdata);
         error_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_rate(input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= RATE_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      rate_60 = value[0];
      check_rate();
   endtask

   task automatic send_random_command();
      logic [2:0]        cmd;
      logic [KEY_W-1:0]  key;
      logic [SECS_W-1:0] secs;
      int                roll;
      int                pick;
      roll = $urandom_range(0, 99);
      key  = KEY_W'(KEY_BASE + $urandom_range(0, KEY_SPAN - 1));
      if ($urandom_range(0, 19) == 0)
         key = KEY_W'($urandom);
      secs = SECS_W'(1 + key % 3);
      case ($urandom_range(0, 9))
         0: secs = '0;
         1: secs = SECS_W'($urandom);
         default: ;
      endcase
      if (roll < 55) begin
         cmd = CMD_TICK;
      end else if (roll < 60) begin
         cmd = CMD_CREATE;
      end else if (roll < 63) begin
         cmd  = CMD_REMOVE;
         pick = $urandom_range(0, SLOTS - 1);
         if (pool_used[pick] && $urandom_range(0, 4) != 0)
            key = pool_key[pick];
      end else if (roll < 80) begin
         cmd = CMD_COUNT;
      end else if (roll < 97) begin
         cmd = CMD_REMAIN;
      end else begin
         cmd = CMD_REMAIN + 3'($urandom_range(1, 3));
      end
      send_command(cmd, key, secs);
   endtask

   task automatic test_zero_and_spare_codes();
      send_command(CMD_COUNT, '0, '0);
      send_command(CMD_REMAIN, '1, '0);
      for (int c = CMD_REMAIN + 1; c <= CMD_LAST; c++)
         send_command(3'(c), '1, '1);
      send_command(CMD_REMOVE, 8'h5A, '0);
      send_command(CMD_CREATE, '1, '0);
      send_command(CMD_REMAIN, '1, '1);
      send_command(CMD_COUNT, '1, '1);
   endtask

   task automatic test_pool_full();
      for (int k = 0; k < SLOTS; k++)
         send_command(CMD_CREATE, KEY_W'(8'h10 + k), '0);
      send_command(CMD_COUNT, 8'h20, 8'd3);
      send_command(CMD_REMAIN, 8'h21, 8'd200);
      send_command(CMD_REMOVE, 8'h10, '0);
      send_command(CMD_REMOVE, '1, '0);
      send_command(CMD_COUNT, 8'h1F, 8'd2);
   endtask

   task automatic test_expiry();
      wait_for_replies();
      write_rate(32'hFFFF_FFFE);
      send_command(CMD_COUNT, 8'h30, 8'd1);
      send_command(CMD_REMAIN, 8'h30, 8'd1);
      repeat (TPS_50 - 1) send_command(CMD_TICK, '0, '0);
      send_command(CMD_COUNT, 8'h30, 8'd1);
      send_command(CMD_TICK, '1, '1);
      send_command(CMD_COUNT, 8'h30, 8'd1);
      send_command(CMD_REMAIN, 8'h30, 8'd1);
      send_command(CMD_REMAIN, 8'h30, 8'd2);
   endtask

   task automatic test_random_traffic();
      logic [CSR_DATA_W-1:0] value;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_replies();
         value    = CSR_DATA_W'($urandom);
         value[0] = (phase % 2 == 0);
         write_rate(value);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0)
               idling = ($urandom_range(0, 3) != 0);
            send_random_command();
            pace_input();
         end
      end
      idling = 1'b1;
   endtask

   task automatic test_backpressure();
      wait_for_replies();
      pop_hold_request = HOLD_CYCLES;
      repeat (12) send_random_command();
      wait_for_replies();
   endtask

   task automatic test_back_to_back();
      wait_for_replies();
      write_rate(32'h1);
      idling = 1'b0;
      for (int s = 0; s < SLOTS; s++)
         if (pool_used[s])
            send_command(CMD_REMOVE, pool_key[s], '0);
      send_command(CMD_COUNT, KEY_A, 8'd1);
      send_command(CMD_REMAIN, KEY_C, 8'd3);
      repeat (TPS_60) send_command(CMD_TICK, '0, '0);
      send_command(CMD_COUNT, KEY_A, 8'd1);
      send_command(CMD_COUNT, KEY_B, 8'd2);
      send_command(CMD_REMAIN, KEY_C, 8'd3);
      repeat (SETTLE_TICKS) send_command(CMD_TICK, '0, '0);
      send_command(CMD_REMAIN, KEY_A, 8'd1);
      send_command(CMD_COUNT, KEY_A, 8'd1);
      send_command(CMD_COUNT, KEY_B, 8'd2);
      send_command(CMD_REMAIN, KEY_C, 8'd3);
      send_command(CMD_COUNT, KEY_C, 8'd3);
   endtask

   initial begin : pop_driver
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (pop_hold_request != 0) begin
            stall = pop_hold_request;
            pop_hold_request = 0;
         end else if (stall == 0 && idling && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 9);
         end
         if (stall > 0) begin
            pop <= 1'b0;
            stall--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : reply_checker
      reply_type want;
      string     want_s;
      string     got_s;
      if (!reset && pop && !empty) begin
         got_s = $sformatf("done=%0d left=%0d full=%0d",
                           rsp_done_res, rsp_seconds_left, rsp_pool_full);
         if (pending_replies.size() == 0) begin
            if (error_count < MAX_REPORTS)
               $display("%0t: unexpected result: expected none, actual %s",
                        $time, got_s);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_done_res !== want.done_res || rsp_seconds_left !== want.seconds_left ||
                rsp_pool_full !== want.pool_full) begin
               want_s = $sformatf("done=%0d left=%0d full=%0d",
                                  want.done_res, want.seconds_left, want.pool_full);
               if (error_count < MAX_REPORTS)
                  $display("%0t: result mismatch: expected %s, actual %s",
                           $time, want_s, got_s);
               error_count++;
            end
         end
      end
   end

   initial begin
      #50ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      for (int s = 0; s < SLOTS; s++)
         clear_slot(s, 1'b0, '0);
      tick_now = '0;
      rate_60  = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_rate();
      test_zero_and_spare_codes();
      test_pool_full();
      test_expiry();
      test_random_traffic();
      test_backpressure();
      test_back_to_back();
      wait_for_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
